/* hw/rtl/acquisition_command_decoder_unit_assert.svh */
// ----------------------------------------------------------------------------
// Acquisition command decoder assertion macros
// Clocked assertion shorthands used at the end of the decoder top level.
// ----------------------------------------------------------------------------
`ifndef ACQUISITION_COMMAND_DECODER_UNIT_ASSERT_SVH
`define ACQUISITION_COMMAND_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ACDU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ACDU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/acdu_pkg.sv */
// ----------------------------------------------------------------------------
// Acquisition command decoder package
// Mode and command codes, register indexes and the rate compare table.
// ----------------------------------------------------------------------------
package acdu_pkg;

	// Channel list geometry; the command byte carries six mask bits.
	localparam int CHANNELS     = 6;
	localparam int ENTRY_W      = 4;
	localparam int LIST_W       = CHANNELS * ENTRY_W;
	localparam int COUNT_W      = 3;
	localparam int THRESH_W     = 10;
	localparam int COMPARE_W    = 15;
	localparam int MASK_LSB     = 2;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_LIVE = 2'd1,
		MODE_SIM  = 2'd2
	} mode_t;

	// Command class, bits 1..0 of the byte.
	localparam logic [1:0] CLS_THRESH = 2'b00;
	localparam logic [1:0] CLS_LIVE   = 2'b01;
	localparam logic [1:0] CLS_SIM    = 2'b10;
	localparam logic [1:0] CLS_MISC   = 2'b11;

	localparam logic [7:0] CMD_VERSION = 8'h07;
	localparam logic [7:0] CMD_STOP    = 8'h00;

	// Configuration register indexes.
	localparam logic [0:0] REG_BATTERY_BASE = 1'b0;
	localparam logic [0:0] REG_ADC_MAP      = 1'b1;

	localparam logic [THRESH_W-1:0] BATTERY_BASE_RST = 10'd527;
	localparam logic [LIST_W-1:0]   ADC_MAP_RST      = 24'h563412;
	localparam logic [1:0]          RATE_RST         = 2'd3;
	localparam logic [THRESH_W-1:0] THRESH_MAX       = 10'd1023;

	// Timer compare value for each rate code (1, 10, 100, 1000 Hz).
	function automatic logic [COMPARE_W-1:0] rate_compare(input logic [1:0] code);
		logic [COMPARE_W-1:0] val;
		case (code)
			2'd0: val = 15'd31249;
			2'd1: val = 15'd3124;
			2'd2: val = 15'd1249;
			2'd3: val = 15'd124;
			default: val = 15'd124;
		endcase
		return val;
	endfunction

endpackage

/* hw/rtl/acquisition_command_decoder_unit.sv */
// Path: an accepted command word goes from the input register to the result register.
// Throughput: one command word per cycle unless the result stream stalls; the input
// and result registers form a two-stage pipeline; decode and compaction fit one stage.
// Reset: arst_n clears both stages, returns to idle at 1000 Hz with the default
// battery base and channel map, an empty channel list and a zero output port.
// ----------------------------------------------------------------------------
// Acquisition command decoder
// Decodes command bytes into mode, rate, threshold, channel list and outputs.
// ----------------------------------------------------------------------------
module acquisition_command_decoder_unit
	import acdu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Command stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] cmd_byte
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] mode, [16:2] compare_value, [17] prescale_256, [27:18] battery_threshold,
	// [30:28] channel_count, [54:31] channel_list, [62:55] digital_out, [63] zero
	output logic [63:0] m_axis_tdata,
	// [0] version_request, [1] acquisition_started, [2] battery_led_clear,
	// [3] acquisition_stopped
	output logic [3:0]  m_axis_tuser,
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	logic                cmd_valid_s1;
	logic [7:0]          cmd_s1;
	logic                advance;

	logic [THRESH_W-1:0] battery_base_q;
	logic [LIST_W-1:0]   adc_map_q;

	mode_t               mode_q,      mode_d;
	logic [1:0]          rate_q,      rate_d;
	logic [THRESH_W-1:0] thresh_q,    thresh_d;
	logic [COUNT_W-1:0]  count_q,     count_d;
	logic [LIST_W-1:0]   list_q,      list_d;
	logic [7:0]          port_q,      port_d;
	logic [3:0]          flags_d;

	logic [ENTRY_W-1:0]  entry       [CHANNELS];
	logic [COUNT_W-1:0]  fill;
	logic [THRESH_W:0]   thresh_sum;

	assign cfg_ready     = 1'b1;
	assign advance       = cmd_valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !cmd_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			battery_base_q <= BATTERY_BASE_RST;
			adc_map_q      <= ADC_MAP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BATTERY_BASE: battery_base_q <= cfg_data[THRESH_W-1:0];
				REG_ADC_MAP:      adc_map_q      <= cfg_data[LIST_W-1:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			cmd_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1 <= s_axis_tdata;
		end
	end

	// Compaction of the six mask bits into an ordered source list.
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			entry[i] = '0;
		end
		fill = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (cmd_s1[MASK_LSB + i]) begin
				entry[fill] = (cmd_s1[1:0] == CLS_SIM) ? ENTRY_W'(i)
					: adc_map_q[ENTRY_W*i +: ENTRY_W];
				fill = fill + 3'd1;
			end
		end
	end

	assign thresh_sum = {1'b0, battery_base_q} + {5'd0, cmd_s1[7:2]};

	always_comb begin
		mode_d   = mode_q;
		rate_d   = rate_q;
		thresh_d = thresh_q;
		count_d  = count_q;
		list_d   = list_q;
		port_d   = port_q;
		flags_d  = 4'b0000;
		if (mode_q == MODE_IDLE) begin
			case (cmd_s1[1:0])
				CLS_THRESH: begin
					thresh_d   = thresh_sum[THRESH_W] ? THRESH_MAX : thresh_sum[THRESH_W-1:0];
					flags_d[2] = 1'b1;
				end
				CLS_LIVE, CLS_SIM: begin
					mode_d  = (cmd_s1[1:0] == CLS_SIM) ? MODE_SIM : MODE_LIVE;
					count_d = fill;
					for (int k = 0; k < CHANNELS; k++) begin
						list_d[ENTRY_W*k +: ENTRY_W] = entry[k];
					end
					flags_d[1] = 1'b1;
				end
				CLS_MISC: begin
					if (cmd_s1 == CMD_VERSION) begin
						flags_d[0] = 1'b1;
					end else begin
						rate_d = cmd_s1[7:6];
					end
				end
				default: ;
			endcase
		end else begin
			// Any acquiring mode, including the unused code, takes stop and port writes.
			if (cmd_s1 == CMD_STOP) begin
				mode_d     = MODE_IDLE;
				flags_d[3] = 1'b1;
			end else if (cmd_s1[1:0] == CLS_MISC) begin
				port_d = cmd_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			rate_q   <= RATE_RST;
			thresh_q <= BATTERY_BASE_RST;
			count_q  <= '0;
			list_q   <= '0;
			port_q   <= '0;
		end else if (advance) begin
			mode_q   <= mode_d;
			rate_q   <= rate_d;
			thresh_q <= thresh_d;
			count_q  <= count_d;
			list_q   <= list_d;
			port_q   <= port_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_axis_tdata <= {1'b0, port_d, list_d, count_d, thresh_d, !rate_d[1],
				rate_compare(rate_d), mode_d};
			m_axis_tuser <= flags_d;
		end
	end

	`include "acquisition_command_decoder_unit_assert.svh"

	`ACDU_ASSERT_NOW(a_one_event, m_axis_tvalid, $onehot0(m_axis_tuser), "more than one event flag")
	`ACDU_ASSERT_NOW(a_start_mode, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata[1:0] != MODE_IDLE, "start left decoder idle")
	`ACDU_ASSERT_NOW(a_stop_mode, m_axis_tvalid && m_axis_tuser[3], m_axis_tdata[1:0] == MODE_IDLE, "stop left decoder acquiring")
	`ACDU_ASSERT_NEXT(a_mode_hold, !advance, $stable(mode_q) && $stable(list_q), "state changed without a command")

endmodule
